/* design/tpd_pkg.sv */
// tpd_pkg: types and constants shared by the touchpad packet decoder.
// No dependencies; imported by tpd_frame_dec and touchpad_packet_decoder_core.
package tpd_pkg;

	localparam int FINGER_SLOTS = 4;
	localparam int PACKET_BYTES = 8;
	localparam int FRAME_BYTES  = 2 * PACKET_BYTES;
	localparam int GROUP_BYTES  = FRAME_BYTES / FINGER_SLOTS;

	localparam int BYTE_W  = 8;
	localparam int POS_W   = 12;
	localparam int PRESS_W = 9;
	localparam int COUNT_W = 4;
	localparam int SLOT_W  = $clog2(FINGER_SLOTS);
	localparam int BPOS_W  = $clog2(PACKET_BYTES);

	localparam logic [BYTE_W-1:0]  BYTE_FF          = 8'hff;
	localparam logic [PRESS_W-1:0] PRESS_LIMIT_RST  = 9'd255;
	localparam logic [SLOT_W-1:0]  LAST_SLOT        = SLOT_W'(FINGER_SLOTS - 1);
	localparam logic [BPOS_W-1:0]  LAST_BYTE        = BPOS_W'(PACKET_BYTES - 1);

	// header type, bits 5:4 of byte 0
	typedef enum logic [1:0] {
		HDR_POS   = 2'd0,
		HDR_SIZE  = 2'd1,
		HDR_EXTRA = 2'd2,
		HDR_OTHER = 2'd3
	} hdr_type_t;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef byte_t [FRAME_BYTES-1:0] frame_t;
	typedef byte_t [PACKET_BYTES-1:0] packet_t;

	typedef struct packed {
		logic               valid;
		logic [POS_W-1:0]   x;
		logic [POS_W-1:0]   y;
		logic [BYTE_W-1:0]  major;
		logic [BYTE_W-1:0]  minor;
		logic [PRESS_W-1:0] pressure;
	} slot_t;

	typedef slot_t [FINGER_SLOTS-1:0] slots_t;

	typedef struct packed {
		logic left;
		logic right;
	} buttons_t;

endpackage

/* design/tpd_frame_dec.sv */
// tpd_frame_dec: decodes one 16-byte frame into next finger slot and button state.
// Purely combinational. Depends on tpd_pkg.
module tpd_frame_dec (
	input  tpd_pkg::frame_t               frame,
	input  logic                          decode_en,
	input  logic [tpd_pkg::COUNT_W-1:0]   count,
	input  logic [tpd_pkg::PRESS_W-1:0]   press_limit,
	input  tpd_pkg::slots_t               slots_cur,
	input  tpd_pkg::buttons_t             btn_cur,
	output tpd_pkg::slots_t               slots_nxt,
	output tpd_pkg::buttons_t             btn_nxt
);
	import tpd_pkg::*;

	logic [FINGER_SLOTS-1:0] empty;
	logic [PRESS_W-1:0]      press_dbl [FINGER_SLOTS];
	logic                    blank;
	logic                    size_hdr;

	always_comb begin
		blank    = (frame[0] == BYTE_FF) && (frame[1] == BYTE_FF) &&
			(frame[2] == BYTE_FF) && (frame[3] == BYTE_FF);
		size_hdr = (frame[0][5:4] == HDR_SIZE);
		for (int i = 0; i < FINGER_SLOTS; i++) begin
			empty[i] = (frame[GROUP_BYTES*i+1] == BYTE_FF) &&
				(frame[GROUP_BYTES*i+2] == BYTE_FF) &&
				(frame[GROUP_BYTES*i+3] == BYTE_FF);
			press_dbl[i] = {frame[GROUP_BYTES*i+3], 1'b0};
		end
	end

	always_comb begin
		slots_nxt = slots_cur;
		btn_nxt   = btn_cur;
		if (decode_en && !blank) begin
			btn_nxt.left  = frame[0][0];
			btn_nxt.right = frame[0][1];
			for (int i = 0; i < FINGER_SLOTS; i++) begin
				if (size_hdr) begin
					if (!empty[i]) begin
						slots_nxt[i].minor    = frame[GROUP_BYTES*i+1];
						slots_nxt[i].major    = frame[GROUP_BYTES*i+2];
						slots_nxt[i].pressure = (press_dbl[i] > press_limit) ?
							press_limit : press_dbl[i];
					end
				end else if (!empty[i]) begin
					slots_nxt[i].valid = 1'b1;
					slots_nxt[i].x     = {frame[GROUP_BYTES*i+1], frame[GROUP_BYTES*i+3][7:4]};
					slots_nxt[i].y     = {frame[GROUP_BYTES*i+2], frame[GROUP_BYTES*i+3][3:0]};
				end else begin
					slots_nxt[i].valid = 1'b0;
				end
			end
			if (count == '0) begin
				for (int i = 0; i < FINGER_SLOTS; i++) begin
					slots_nxt[i].valid = 1'b0;
				end
			end
		end
	end

endmodule

/* design/touchpad_packet_decoder_core.sv */
// touchpad_packet_decoder_core: gathers touchpad bytes into packets and frames,
// keeps finger slot state and emits four slot records per packet.
// Depends on tpd_pkg and tpd_frame_dec.
//
//  channel  direction  handshake              payload
//  in       request    in_valid / in_stall    data_byte
//  out      result     out_valid / out_stall  slot .. last (11 fields)
//  cfg      write      cfg_wr_en              cfg_wr_data (pressure limit)
//
// One byte is taken per cycle while in_stall is low. The eighth byte of a packet
// is decoded in the following cycle, then four records leave one per cycle from
// the slot registers while out_stall is low; records overlap the next packet's bytes.
// in_stall rises only on a packet's last byte while records of the previous one wait.
// arst_n clears all slot state, buttons, count and frame; the pressure limit resets to 255.
module touchpad_packet_decoder_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [tpd_pkg::PRESS_W-1:0]   cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [tpd_pkg::BYTE_W-1:0]    data_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [tpd_pkg::SLOT_W-1:0]    slot,
	output logic                          valid_res,
	output logic [tpd_pkg::POS_W-1:0]     pos_x,
	output logic [tpd_pkg::POS_W-1:0]     pos_y,
	output logic [tpd_pkg::BYTE_W-1:0]    touch_major,
	output logic [tpd_pkg::BYTE_W-1:0]    touch_minor,
	output logic [tpd_pkg::PRESS_W-1:0]   pressure,
	output logic                          left_pressed,
	output logic                          right_pressed,
	output logic [tpd_pkg::COUNT_W-1:0]   finger_total,
	output logic                          last
);
	import tpd_pkg::*;

	logic [PRESS_W-1:0] press_limit_q;
	packet_t            pkt_q;
	packet_t            frame_lo_q;
	logic [BPOS_W-1:0]  bpos_q;
	logic               pend_s1;
	logic               await_q;
	logic               busy_q;
	logic [SLOT_W-1:0]  slot_q;
	slots_t             slots_q;
	buttons_t           btn_q;
	logic [COUNT_W-1:0] count_q;

	logic               in_acc;
	logic               out_acc;
	frame_t             frame_nxt;
	logic [COUNT_W-1:0] count_nxt;
	logic               await_nxt;
	slots_t             slots_nxt;
	buttons_t           btn_nxt;
	slot_t              cur;

	assign in_stall = (bpos_q == LAST_BYTE) && (pend_s1 || busy_q);
	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_limit_q <= PRESS_LIMIT_RST;
		end else if (cfg_wr_en) begin
			press_limit_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pkt_q[bpos_q] <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpos_q  <= '0;
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= in_acc && (bpos_q == LAST_BYTE);
			if (in_acc) begin
				bpos_q <= bpos_q + 1'b1;
			end
		end
	end

	// frame assembly for the packet now complete in pkt_q
	always_comb begin
		if (!await_q) begin
			for (int i = 0; i < PACKET_BYTES; i++) begin
				frame_nxt[i]                = pkt_q[i];
				frame_nxt[i + PACKET_BYTES] = BYTE_FF;
			end
			count_nxt = {pkt_q[4][5:4], pkt_q[4][1:0]};
			await_nxt = (count_nxt > COUNT_W'(2)) &&
				(pkt_q[0] != BYTE_FF) && (pkt_q[1] != BYTE_FF) &&
				(pkt_q[2] != BYTE_FF) && (pkt_q[3] != BYTE_FF) &&
				(pkt_q[0][5:4] != HDR_EXTRA);
		end else begin
			for (int i = 0; i < PACKET_BYTES; i++) begin
				frame_nxt[i]                = frame_lo_q[i];
				frame_nxt[i + PACKET_BYTES] = pkt_q[i];
			end
			count_nxt = count_q;
			await_nxt = 1'b0;
		end
	end

	tpd_frame_dec u_dec (
		.frame        (frame_nxt),
		.decode_en    (!await_nxt),
		.count        (count_nxt),
		.press_limit  (press_limit_q),
		.slots_cur    (slots_q),
		.btn_cur      (btn_q),
		.slots_nxt    (slots_nxt),
		.btn_nxt      (btn_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			await_q    <= 1'b0;
			count_q    <= '0;
			slots_q    <= '0;
			btn_q      <= '0;
			frame_lo_q <= '0;
		end else if (pend_s1) begin
			await_q <= await_nxt;
			count_q <= count_nxt;
			slots_q <= slots_nxt;
			btn_q   <= btn_nxt;
			for (int i = 0; i < PACKET_BYTES; i++) begin
				frame_lo_q[i] <= frame_nxt[i];
			end
		end
	end

	// record emission, one slot per accepted result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			slot_q <= '0;
		end else begin
			if (pend_s1) begin
				busy_q <= 1'b1;
			end else if (out_acc && (slot_q == LAST_SLOT)) begin
				busy_q <= 1'b0;
			end
			if (out_acc) begin
				slot_q <= slot_q + 1'b1;
			end
		end
	end

	assign cur           = slots_q[slot_q];
	assign out_valid     = busy_q;
	assign slot          = slot_q;
	assign valid_res     = cur.valid;
	assign pos_x         = cur.valid ? cur.x : '0;
	assign pos_y         = cur.valid ? cur.y : '0;
	assign touch_major   = cur.valid ? cur.major : '0;
	assign touch_minor   = cur.valid ? cur.minor : '0;
	assign pressure      = cur.valid ? cur.pressure : '0;
	assign left_pressed  = btn_q.left;
	assign right_pressed = btn_q.right;
	assign finger_total  = count_q;
	assign last          = (slot_q == LAST_SLOT);

	a_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> !busy_q)
		else $error("packet decoded while records still pending");

	a_pend_emit: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |=> busy_q)
		else $error("decoded packet produced no records");

	a_first_slot: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> (slot == '0))
		else $error("record burst does not start at slot zero");

	a_burst_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && last) |=> !out_valid)
		else $error("records continue past the last slot");

endmodule
